// ----- hw/rtl/lspt_pkg.sv -----
package lspt_pkg;

  // Sensor array geometry
  localparam int SENSOR_COUNT = 5;
  localparam int SAMPLE_BITS  = 10;

  // Result field widths
  localparam int POS_BITS   = 12;
  localparam int STATE_BITS = 3;

  // Detection count, 0..SENSOR_COUNT
  localparam int CNT_BITS = $clog2(SENSOR_COUNT + 1);
  // Signed sum of doubled weights, covers up to eight sensors
  localparam int SUM_BITS = 7;

  // Divider: magnitude of 128 * sum2, one quotient bit per cycle
  localparam int POS_SHIFT = 7;
  localparam int DIV_BITS  = POS_BITS;
  localparam int STEP_BITS = $clog2(DIV_BITS + 1);

  // Queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(512);
  localparam logic [DIV_BITS-1:0]    LOST_VALUE   = DIV_BITS'(1280);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Action codes as carried by the input beat
  typedef enum logic [1:0] {
    ACT_CAL_FIRST = 2'd0,
    ACT_CAL_ACC   = 2'd1,
    ACT_APPLY     = 2'd2,
    ACT_MEASURE   = 2'd3
  } action_e;

  // Decoded operation handed to the back end
  typedef enum logic [3:0] {
    OP_CAL_FIRST = 4'b0001,
    OP_CAL_ACC   = 4'b0010,
    OP_APPLY     = 4'b0100,
    OP_MEASURE   = 4'b1000
  } op_e;

  typedef enum logic [STATE_BITS-1:0] {
    ST_LEFT     = 3'd0,
    ST_RIGHT    = 3'd1,
    ST_CENTERED = 3'd2,
    ST_LOST     = 3'd3,
    ST_JUNCTION = 3'd4
  } line_state_e;

  typedef struct packed {
    logic [1:0] action;
    sample_t    sample_0;
    sample_t    sample_1;
    sample_t    sample_2;
    sample_t    sample_3;
    sample_t    sample_4;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] position_error;
    logic [STATE_BITS-1:0]      line_state;
    logic [SENSOR_COUNT-1:0]    detect_mask;
  } out_item_t;

  typedef struct packed {
    op_e                                     op;
    logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] samples;
  } q_entry_t;

  // Doubled sensor weight: 2i - (SENSOR_COUNT - 1)
  function automatic logic signed [SUM_BITS-1:0] weight2(input int idx);
    return SUM_BITS'(2 * idx - (SENSOR_COUNT - 1));
  endfunction

endpackage

// ----- hw/rtl/lspt_front.sv -----
module lspt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lspt_pkg::in_item_t in_item_i,
  output logic               push_valid_o,
  input  logic               push_stall_i,
  output lspt_pkg::q_entry_t push_entry_o
);
  import lspt_pkg::*;

  logic     valid_q, valid_d;
  logic     load;
  q_entry_t entry_q, entry_d;

  // Stage holds while the queue is full
  assign in_stall_o = valid_q & push_stall_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & push_stall_i);

  // Decode action and gather samples
  always_comb begin
    entry_d            = '0;
    entry_d.samples[0] = in_item_i.sample_0;
    entry_d.samples[1] = in_item_i.sample_1;
    entry_d.samples[2] = in_item_i.sample_2;
    entry_d.samples[3] = in_item_i.sample_3;
    entry_d.samples[4] = in_item_i.sample_4;
    unique case (action_e'(in_item_i.action))
      ACT_CAL_FIRST: entry_d.op = OP_CAL_FIRST;
      ACT_CAL_ACC:   entry_d.op = OP_CAL_ACC;
      ACT_APPLY:     entry_d.op = OP_APPLY;
      ACT_MEASURE:   entry_d.op = OP_MEASURE;
      default:       entry_d.op = OP_MEASURE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= entry_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

endmodule

// ----- hw/rtl/lspt_queue.sv -----
module lspt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_stall_o,
  input  lspt_pkg::q_entry_t push_entry_i,
  output logic               pop_valid_o,
  input  logic               pop_stall_i,
  output lspt_pkg::q_entry_t pop_entry_o
);
  import lspt_pkg::*;

  q_entry_t             slot_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_BITS:0]    count_q, count_d;
  logic                 push_fire, pop_fire;

  assign push_stall_o = (count_q == (PTR_BITS + 1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push_fire    = push_valid_i & ~push_stall_o;
  assign pop_fire     = pop_valid_o & ~pop_stall_i;
  assign pop_entry_o  = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_fire ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_fire ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_fire && !pop_fire) begin
      count_d = count_q + 1'b1;
    end else if (!push_fire && pop_fire) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_BITS + 1)'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[PTR_BITS-1:0])
    else $error("queue pointers disagree with fill count");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_fire && !pop_fire) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue push lost");
`endif

endmodule

// ----- hw/rtl/lspt_back.sv -----
module lspt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_stall_o,
  input  lspt_pkg::q_entry_t  pop_entry_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lspt_pkg::out_item_t out_item_o
);
  import lspt_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  sample_t thr_q  [SENSOR_COUNT];
  sample_t thr_d  [SENSOR_COUNT];
  sample_t low_q  [SENSOR_COUNT];
  sample_t low_d  [SENSOR_COUNT];
  sample_t high_q [SENSOR_COUNT];
  sample_t high_d [SENSOR_COUNT];

  logic                    take;
  logic [SENSOR_COUNT-1:0] det;
  logic signed [SUM_BITS-1:0] sum2;
  logic signed [SUM_BITS-1:0] cnt_s;
  logic [CNT_BITS-1:0]     cnt;
  logic [SUM_BITS-1:0]     abs_sum;
  logic [DIV_BITS-1:0]     mag;
  line_state_e             cls;
  logic [SAMPLE_BITS:0]    mid [SENSOR_COUNT];

  // Measure result and divider registers
  logic [SENSOR_COUNT-1:0] mask_q, mask_d;
  line_state_e             line_q, line_d;
  logic                    neg_q, neg_d;
  logic [CNT_BITS-1:0]     dvs_q, dvs_d;
  logic [DIV_BITS-1:0]     dq_q, dq_d;
  logic [CNT_BITS-1:0]     rem_q, rem_d;
  logic [STEP_BITS-1:0]    step_q, step_d;
  logic [CNT_BITS:0]       shift_rem;
  logic [CNT_BITS:0]       sub_rem;
  logic                    qbit;

  logic                    out_valid_q, out_valid_d;
  logic                    load_out;
  out_item_t               out_item_q, out_item_d;

  assign pop_stall_o = (state_q != BK_IDLE);
  assign take        = pop_valid_i & (state_q == BK_IDLE);

  // Detection, weighted sum and count over the sensor row
  always_comb begin
    sum2 = '0;
    cnt  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      det[i] = pop_entry_i.samples[i] > thr_q[i];
      sum2   = sum2 + (det[i] ? weight2(i) : SUM_BITS'(0));
      cnt    = cnt + CNT_BITS'(det[i]);
    end
    cnt_s   = signed'(SUM_BITS'(cnt));
    abs_sum = sum2[SUM_BITS-1] ? SUM_BITS'(-sum2) : SUM_BITS'(sum2);
    mag     = DIV_BITS'({abs_sum, {POS_SHIFT{1'b0}}});
    if (sum2 < -cnt_s) begin
      cls = ST_LEFT;
    end else if (sum2 > cnt_s) begin
      cls = ST_RIGHT;
    end else begin
      cls = ST_CENTERED;
    end
  end

  // One restoring divide step
  always_comb begin
    shift_rem = {rem_q, dq_q[DIV_BITS-1]};
    qbit      = shift_rem >= {1'b0, dvs_q};
    sub_rem   = shift_rem - {1'b0, dvs_q};
  end

  // Calibration updates
  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      low_d[i]  = low_q[i];
      high_d[i] = high_q[i];
      thr_d[i]  = thr_q[i];
      mid[i]    = {1'b0, low_q[i]} + {1'b0, high_q[i]};
      if (take) begin
        unique case (pop_entry_i.op)
          OP_CAL_FIRST: begin
            low_d[i]  = pop_entry_i.samples[i];
            high_d[i] = pop_entry_i.samples[i];
          end
          OP_CAL_ACC: begin
            if (pop_entry_i.samples[i] < low_q[i]) low_d[i] = pop_entry_i.samples[i];
            if (pop_entry_i.samples[i] > high_q[i]) high_d[i] = pop_entry_i.samples[i];
          end
          OP_APPLY: begin
            thr_d[i] = mid[i][SAMPLE_BITS:1];
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer for measure beats
  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    line_d  = line_q;
    neg_d   = neg_q;
    dvs_d   = dvs_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    step_d  = step_q;
    load_out   = 1'b0;
    out_item_d = out_item_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take && pop_entry_i.op == OP_MEASURE) begin
          mask_d  = det;
          state_d = BK_DONE;
          neg_d   = 1'b0;
          if (cnt == '0) begin
            line_d = ST_LOST;
            dq_d   = LOST_VALUE;
          end else if (cnt == CNT_BITS'(SENSOR_COUNT)) begin
            line_d = ST_JUNCTION;
            dq_d   = '0;
          end else begin
            line_d  = cls;
            neg_d   = sum2[SUM_BITS-1];
            dvs_d   = cnt;
            dq_d    = mag;
            rem_d   = '0;
            step_d  = '0;
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        dq_d   = {dq_q[DIV_BITS-2:0], qbit};
        rem_d  = qbit ? sub_rem[CNT_BITS-1:0] : shift_rem[CNT_BITS-1:0];
        step_d = step_q + 1'b1;
        if (step_q == STEP_BITS'(DIV_BITS - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out                  = 1'b1;
          out_item_d.position_error = neg_q ? signed'(-dq_q) : signed'(dq_q);
          out_item_d.line_state     = line_q;
          out_item_d.detect_mask    = mask_q;
          state_d                   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        thr_q[i] <= THRESH_RESET;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
    end
  end

  // Marks and datapath registers carry no reset
  always_ff @(posedge clk_i) begin
    low_q      <= low_d;
    high_q     <= high_d;
    mask_q     <= mask_d;
    line_q     <= line_d;
    neg_q      <= neg_d;
    dvs_q      <= dvs_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_div_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (dvs_q != '0 && dvs_q < CNT_BITS'(SENSOR_COUNT)))
    else $error("divider running with an invalid count");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (step_q < STEP_BITS'(DIV_BITS)))
    else $error("divider overran its step count");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_DONE && !out_valid_q) |=> !out_valid_q)
    else $error("result appeared without a finished measure");
`endif

endmodule

// ----- hw/rtl/line_sensor_position_tracker_core.sv -----
// Line sensor position tracker. Each input beat carries five samples and an
// action: calibrate-first and calibrate-accumulate track per-channel low and
// high marks, apply sets each threshold to their midpoint, and measure
// returns one result beat with the detection mask, the mean sensor weight
// times 256 (truncated toward zero; 1280 when no sensor sees the line, 0 when
// all do) and a line state. Beats enter a two-deep queue at up to one per
// cycle; the back end takes calibrate and apply beats in its idle state,
// passes a lost or junction measure through its done state, and runs any
// other measure through its serial divider, one quotient bit per cycle over
// twelve bits, then the done state. Apply must follow a calibrate-first.
module line_sensor_position_tracker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lspt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lspt_pkg::out_item_t out_item_o
);
  import lspt_pkg::*;

  logic     push_valid, push_stall;
  logic     pop_valid, pop_stall;
  q_entry_t push_entry, pop_entry;

  lspt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_entry_o (push_entry)
  );

  lspt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_entry_o  (pop_entry)
  );

  lspt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_stall_o (pop_stall),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- test/line_sensor_position_tracker_core_tb.sv -----
`timescale 1ns / 100ps

module line_sensor_position_tracker_core_tb;
  import lspt_pkg::*;

  typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] sample_vec_t;

  // One directed row: the beat and, where obvious, its reading typed in
  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  localparam int unsigned RANDOM_BEATS = 1600;
  localparam int unsigned PHASE_BEATS  = RANDOM_BEATS / 4;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int          IN_BITS      = $bits(in_item_t);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Idle rates in percent, changed per phase
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned beats_sent     = 0;

  // Tracker copy of the per-channel calibration state
  sample_t low_mark  [SENSOR_COUNT];
  sample_t high_mark [SENSOR_COUNT];
  sample_t thresh    [SENSOR_COUNT];

  out_item_t expected_readings[$];
  stim_row_t stim_table[$];

  line_sensor_position_tracker_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on the run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic in_item_t pack_beat(action_e act, sample_vec_t s);
    in_item_t it;
    it.action   = act;
    it.sample_0 = s[0];
    it.sample_1 = s[1];
    it.sample_2 = s[2];
    it.sample_3 = s[3];
    it.sample_4 = s[4];
    return it;
  endfunction

  // Weighted mean of the detected channels, times 256
  function automatic out_item_t predict_reading(sample_vec_t s);
    out_item_t rd;
    int sum2;
    int cnt;
    int pos;
    sum2 = 0;
    cnt  = 0;
    rd.detect_mask = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (s[i] > thresh[i]) begin
        rd.detect_mask[i] = 1'b1;
        sum2 += 2 * i - (SENSOR_COUNT - 1);
        cnt++;
      end
    end
    if (cnt == 0) begin
      pos = 1280;
      rd.line_state = ST_LOST;
    end else if (cnt == SENSOR_COUNT) begin
      pos = 0;
      rd.line_state = ST_JUNCTION;
    end else begin
      // signed int division truncates toward zero
      pos = (128 * sum2) / cnt;
      if (sum2 < -cnt) rd.line_state = ST_LEFT;
      else if (sum2 > cnt) rd.line_state = ST_RIGHT;
      else rd.line_state = ST_CENTERED;
    end
    rd.position_error = POS_BITS'(pos);
    return rd;
  endfunction

  // Update tracked state; returns 1 when the beat yields a reading
  function automatic bit absorb_beat(in_item_t it, output out_item_t rd);
    sample_vec_t s;
    s  = {it.sample_4, it.sample_3, it.sample_2, it.sample_1, it.sample_0};
    rd = '0;
    case (action_e'(it.action))
      ACT_CAL_FIRST: begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          low_mark[i]  = s[i];
          high_mark[i] = s[i];
        end
      end
      ACT_CAL_ACC: begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          if (s[i] < low_mark[i]) low_mark[i] = s[i];
          if (s[i] > high_mark[i]) high_mark[i] = s[i];
        end
      end
      ACT_APPLY: begin
        for (int i = 0; i < SENSOR_COUNT; i++)
          thresh[i] = SAMPLE_BITS'(({1'b0, low_mark[i]} + {1'b0, high_mark[i]}) >> 1);
      end
      default: begin
        rd = predict_reading(s);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Drive one beat at the falling edge and hold it until accepted
  task automatic drive_beat(in_item_t it);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= in_item_t'(IN_BITS'({$urandom, $urandom}));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_tracked(in_item_t it);
    out_item_t rd;
    drive_beat(it);
    if (absorb_beat(it, rd)) expected_readings.push_back(rd);
    beats_sent++;
  endtask

  task automatic add_row(action_e act, int s0, int s1, int s2, int s3, int s4,
                         bit typed = 1'b0, int pos = 0,
                         line_state_e st = ST_LOST, int mask = 0);
    stim_row_t row;
    row.beat  = pack_beat(act, {sample_t'(s4), sample_t'(s3), sample_t'(s2),
                                sample_t'(s1), sample_t'(s0)});
    row.typed = typed;
    row.want.position_error = POS_BITS'(pos);
    row.want.line_state     = st;
    row.want.detect_mask    = SENSOR_COUNT'(mask);
    stim_table.push_back(row);
  endtask

  // Measure beat: pick a detect pattern, then place samples around thresholds
  function automatic in_item_t make_measure();
    sample_vec_t s;
    logic [SENSOR_COUNT-1:0] want;
    int unsigned style;
    int unsigned thr;
    want  = SENSOR_COUNT'($urandom_range(31));
    style = $urandom_range(9);
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      thr = int'(thresh[i]);
      if (style == 0)
        s[i] = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
      else if (want[i] && thr != SAMPLE_MAX)
        s[i] = SAMPLE_BITS'((style == 1) ? thr + 1 : $urandom_range(SAMPLE_MAX, thr + 1));
      else
        s[i] = SAMPLE_BITS'((style == 1) ? thr : $urandom_range(thr, 0));
    end
    return pack_beat(ACT_MEASURE, s);
  endfunction

  // Random part: mostly calibrate sweeps followed by measures, some noise
  task automatic run_random(int unsigned n_beats);
    int unsigned stop_at;
    int unsigned a;
    int unsigned b;
    int unsigned lo [SENSOR_COUNT];
    int unsigned hi [SENSOR_COUNT];
    sample_vec_t s;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          a = $urandom_range(SAMPLE_MAX);
          b = $urandom_range(SAMPLE_MAX);
          lo[i] = (a < b) ? a : b;
          hi[i] = (a < b) ? b : a;
        end
        for (int i = 0; i < SENSOR_COUNT; i++)
          s[i] = SAMPLE_BITS'($urandom_range(hi[i], lo[i]));
        send_tracked(pack_beat(ACT_CAL_FIRST, s));
        repeat ($urandom_range(6)) begin
          for (int i = 0; i < SENSOR_COUNT; i++)
            s[i] = SAMPLE_BITS'($urandom_range(hi[i], lo[i]));
          send_tracked(pack_beat(ACT_CAL_ACC, s));
        end
        for (int i = 0; i < SENSOR_COUNT; i++)
          s[i] = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
        send_tracked(pack_beat(ACT_APPLY, s));
        repeat ($urandom_range(12, 2)) send_tracked(make_measure());
      end else begin
        for (int i = 0; i < SENSOR_COUNT; i++)
          s[i] = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
        send_tracked(pack_beat(action_e'($urandom_range(3)), s));
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Receiver stall, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= (snk_stall_pct != 0) && ($urandom_range(99) < snk_stall_pct);
  end

  // Result check at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected reading pos=%0d state=%0d mask=%05b",
                                  out_item.position_error, out_item.line_state,
                                  out_item.detect_mask));
      end else begin
        want = expected_readings.pop_front();
        if (out_item !== want)
          report_mismatch($sformatf(
            "got pos=%0d state=%0d mask=%05b, want pos=%0d state=%0d mask=%05b",
            out_item.position_error, out_item.line_state, out_item.detect_mask,
            want.position_error, want.line_state, want.detect_mask));
      end
    end
  end

  initial begin
    out_item_t rd;
    bit        has_reading;
    int unsigned drain;

    for (int i = 0; i < SENSOR_COUNT; i++) begin
      low_mark[i]  = '0;
      high_mark[i] = '0;
      thresh[i]    = THRESH_RESET;
    end

    // Directed table; thresholds start at 512
    add_row(ACT_MEASURE,    0,    0,    0,    0,    0, 1, 1280, ST_LOST,     'h00);
    add_row(ACT_MEASURE,  512,  512,  512,  512,  512, 1, 1280, ST_LOST,     'h00);
    add_row(ACT_MEASURE,  513,  513,  513,  513,  513, 1,    0, ST_JUNCTION, 'h1f);
    add_row(ACT_MEASURE, 1023, 1023, 1023, 1023, 1023, 1,    0, ST_JUNCTION, 'h1f);
    add_row(ACT_MEASURE, 1023,    0,    0,    0,    0, 1, -512, ST_LEFT,     'h01);
    add_row(ACT_MEASURE,    0,    0,    0,    0, 1023, 1,  512, ST_RIGHT,    'h10);
    add_row(ACT_MEASURE,    0,    0, 1023,    0,    0, 1,    0, ST_CENTERED, 'h04);
    // mean of exactly -0.5 and +0.5, truncated thirds, then -0.5 over four
    add_row(ACT_MEASURE,    0,  513,  513,    0,    0);
    add_row(ACT_MEASURE,    0,    0,  513,  513,    0);
    add_row(ACT_MEASURE,  513,    0,  513,  513,    0);
    add_row(ACT_MEASURE,  513,  513,    0,  513,    0);
    add_row(ACT_MEASURE,    0,  700,    0,  800, 1000);
    add_row(ACT_MEASURE,  600,  600,  600,  600,    0);
    // full-range calibration gives thresholds of 511
    add_row(ACT_CAL_FIRST,  0,    0,    0,    0,    0);
    add_row(ACT_CAL_ACC, 1023, 1023, 1023, 1023, 1023);
    add_row(ACT_APPLY,    300,  300,  300,  300,  300);
    add_row(ACT_MEASURE,  511,  511,  511,  511,  511, 1, 1280, ST_LOST,     'h00);
    add_row(ACT_MEASURE,  512,  512,  512,  512,  512, 1,    0, ST_JUNCTION, 'h1f);
    // mixed marks: accumulate lowers some channels and raises others
    add_row(ACT_CAL_FIRST, 1023, 0, 1023,  0, 1023);
    add_row(ACT_CAL_ACC,    100, 900, 0, 1023, 200);
    add_row(ACT_APPLY,        0,   0,  0,    0,   0);
    add_row(ACT_MEASURE,    600, 400, 512, 511, 1023);
    // top threshold: nothing can exceed it
    add_row(ACT_CAL_FIRST, 1023, 1023, 1023, 1023, 1023);
    add_row(ACT_APPLY,        0,    0,    0,    0,    0);
    add_row(ACT_MEASURE,   1023, 1023, 1023, 1023, 1023, 1, 1280, ST_LOST,    'h00);
    // zero threshold: any nonzero sample detects
    add_row(ACT_CAL_FIRST,    0,    0,    0,    0,    0);
    add_row(ACT_APPLY,     1023, 1023, 1023, 1023, 1023);
    add_row(ACT_MEASURE,      1,    1,    1,    1,    1, 1,    0, ST_JUNCTION, 'h1f);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[k]) begin
      drive_beat(stim_table[k].beat);
      has_reading = absorb_beat(stim_table[k].beat, rd);
      if (has_reading)
        expected_readings.push_back(stim_table[k].typed ? stim_table[k].want : rd);
    end

    // Random phases with different idle patterns
    src_idle_pct = 0;  snk_stall_pct = 0;  run_random(PHASE_BEATS);
    src_idle_pct = 45; snk_stall_pct = 0;  run_random(PHASE_BEATS);
    src_idle_pct = 0;  snk_stall_pct = 45; run_random(PHASE_BEATS);
    src_idle_pct = 15; snk_stall_pct = 15; run_random(PHASE_BEATS);

    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_readings.size() != 0) @(posedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);

    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
